FILE: sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define CHB_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication
`define CHB_ASSERT_IMP(lbl, ante, cons, msg) \
    `CHB_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/chb_pkg.sv
// Package: widths, codes, types and term tables of the Hessian block unit.
`timescale 1ns / 1ps
package chb_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int NODE_W     = 10;
    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUMSQ_W    = PROD_W;
    localparam int RAD_W      = 44;
    localparam int CNT_W      = 11;
    localparam int QUO_W      = 17;
    localparam int REM_W      = SUMSQ_W + 1;
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int ENTRY_W    = 32;
    localparam int ACC_W      = ADDR_W + QUO_W + 1;
    localparam int STATUS_W   = 3;
    localparam int NUM_TERMS  = 6;
    localparam int WORD_W     = 3 * COORD_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RAD_W;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COINCIDENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADINDEX   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 1'b1;
    localparam logic [CNT_W-1:0]     NODE_COUNT_RST = 11'd1;
    localparam logic [RAD_W-1:0]     RADIUS_SQ_RST  = 44'd14745600;

    // Unique terms of the symmetric block: xx, yy, zz, xy, xz, yz
    localparam int T_XX = 0;
    localparam int T_YY = 1;
    localparam int T_ZZ = 2;
    localparam int T_XY = 3;
    localparam int T_XZ = 4;
    localparam int T_YZ = 5;
    localparam int TERM_A [NUM_TERMS] = '{0, 1, 2, 0, 0, 1};
    localparam int TERM_B [NUM_TERMS] = '{0, 1, 2, 1, 2, 2};

    // Controller to datapath commands
    typedef struct packed {
        logic                mem_we;
        logic                mem_rd;
        logic [ADDR_W-1:0]   mem_addr;
        logic                latch_base;
        logic                latch_diff;
        logic                mul;
        logic                sum;
        logic                div_step;
        logic                acc_clear;
        logic                acc_add;
        logic                acc_sub;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic s_zero;
        logic s_far;
    } t_dp_stat;

endpackage

FILE: sv/chb_in_if.sv
// Request channel: operation, node indexes and coordinates.
`timescale 1ns / 1ps
interface chb_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    operation;
    logic [chb_pkg::NODE_W-1:0]              row_node;
    logic [chb_pkg::NODE_W-1:0]              col_node;
    logic signed [chb_pkg::COORD_W-1:0]      coord_x;
    logic signed [chb_pkg::COORD_W-1:0]      coord_y;
    logic signed [chb_pkg::COORD_W-1:0]      coord_z;

    modport source (output valid, operation, row_node, col_node, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, operation, row_node, col_node, coord_x, coord_y, coord_z,
                  output ready);
endinterface

FILE: sv/chb_out_if.sv
// Result channel: nine block entries and a status code.
`timescale 1ns / 1ps
interface chb_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_xx;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_xy;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_xz;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_yx;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_yy;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_yz;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_zx;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_zy;
    logic signed [chb_pkg::ENTRY_W-1:0]  entry_zz;
    logic [chb_pkg::STATUS_W-1:0]        status;

    modport source (output valid, entry_xx, entry_xy, entry_xz, entry_yx, entry_yy,
                    entry_yz, entry_zx, entry_zy, entry_zz, status, input ready);
    modport sink (input valid, entry_xx, entry_xy, entry_xz, entry_yx, entry_yy,
                  entry_yz, entry_zx, entry_zy, entry_zz, status, output ready);
endinterface

FILE: sv/chb_ctrl.sv
// Controller: request decode, neighbor walk and divider sequencing.
`timescale 1ns / 1ps
module chb_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [chb_pkg::NODE_W-1:0]          i_row_node,
    input  logic [chb_pkg::NODE_W-1:0]          i_col_node,
    input  logic                                i_cfg_we,
    input  logic [chb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [chb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  chb_pkg::t_dp_stat                   i_stat,
    output chb_pkg::t_dp_cmd                    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_ROW, S_BASE, S_SEEK, S_RD_PART, S_DIFF, S_MUL, S_SUM,
        S_CHECK, S_DIV, S_ACC, S_FINISH
    } t_state;

    t_state                                r_state, n_state;
    logic [chb_pkg::CNT_W-1:0]             r_node_count;
    logic [chb_pkg::NODE_W-1:0]            r_row, n_row;
    logic                                  r_diag, n_diag;
    logic [chb_pkg::CNT_W-1:0]             r_j, n_j;
    logic                                  r_coinc, n_coinc;
    logic [chb_pkg::STATUS_W-1:0]          r_status, n_status;
    logic [chb_pkg::DIV_CNT_W-1:0]         r_div_cnt, n_div_cnt;
    logic                                  r_out_valid, n_out_valid;
    logic [chb_pkg::CNT_W-1:0]             w_n_eff;
    logic                                  w_accept;
    logic                                  w_row_bad;
    logic                                  w_col_bad;
    logic                                  w_load_bad;

    // Effective node count is capped at the store depth
    assign w_n_eff = (32'(r_node_count) > 32'(chb_pkg::MAX_NODES)) ?
                     chb_pkg::CNT_W'(chb_pkg::MAX_NODES) : r_node_count;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_row_bad  = chb_pkg::CNT_W'(i_row_node) >= w_n_eff;
    assign w_col_bad  = chb_pkg::CNT_W'(i_col_node) >= w_n_eff;
    assign w_load_bad = 32'(i_row_node) >= 32'(chb_pkg::MAX_NODES);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_diag      = r_diag;
        n_j         = r_j;
        n_coinc     = r_coinc;
        n_status    = r_status;
        n_div_cnt   = r_div_cnt;
        n_out_valid = (r_out_valid && i_out_ready) ? 1'b0 : r_out_valid;
        o_cmd       = '0;
        o_cmd.acc_sub = !r_diag;
        o_cmd.status  = r_status;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.mem_addr = chb_pkg::ADDR_W'(i_row_node);
                if (w_accept) begin
                    o_cmd.acc_clear = 1'b1;
                    n_row   = i_row_node;
                    n_diag  = 1'b0;
                    n_coinc = 1'b0;
                    if (i_operation == chb_pkg::OP_LOAD) begin
                        o_cmd.mem_we = !w_load_bad;
                        n_status = w_load_bad ? chb_pkg::ST_BADINDEX : chb_pkg::ST_LOADED;
                        n_state  = S_FINISH;
                    end else if (w_row_bad || w_col_bad) begin
                        n_status = chb_pkg::ST_BADINDEX;
                        n_state  = S_FINISH;
                    end else begin
                        n_status = chb_pkg::ST_OK;
                        n_diag   = (i_row_node == i_col_node);
                        n_j      = (i_row_node == i_col_node) ? '0 :
                                   chb_pkg::CNT_W'(i_col_node);
                        n_state  = S_RD_ROW;
                    end
                end
            end
            S_RD_ROW: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.mem_addr = chb_pkg::ADDR_W'(r_row);
                n_state        = S_BASE;
            end
            S_BASE: begin
                o_cmd.latch_base = 1'b1;
                n_state = r_diag ? S_SEEK : S_RD_PART;
            end
            // Skip the row node itself; stop past the last node
            S_SEEK: begin
                if (r_j >= w_n_eff) begin
                    n_state = S_FINISH;
                end else if (r_j == chb_pkg::CNT_W'(r_row)) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_RD_PART;
                end
            end
            S_RD_PART: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.mem_addr = chb_pkg::ADDR_W'(r_j);
                n_state        = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.latch_diff = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_CHECK;
            end
            // Coincident or out-of-cutoff pairs add nothing
            S_CHECK: begin
                n_div_cnt = '0;
                if (i_stat.s_zero || i_stat.s_far) begin
                    n_coinc = r_coinc || i_stat.s_zero;
                    n_j     = r_j + 1'b1;
                    n_state = r_diag ? S_SEEK : S_FINISH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == chb_pkg::DIV_CNT_W'(chb_pkg::QUO_W - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = r_diag ? S_SEEK : S_FINISH;
            end
            S_FINISH: begin
                o_cmd.status = (r_status == chb_pkg::ST_OK && r_coinc) ?
                               chb_pkg::ST_COINCIDENT : r_status;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, registered outputs and node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_node_count <= chb_pkg::NODE_COUNT_RST;
            r_diag       <= 1'b0;
            r_coinc      <= 1'b0;
            r_status     <= chb_pkg::ST_OK;
            r_j          <= '0;
            r_div_cnt    <= '0;
            r_row        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_diag      <= n_diag;
            r_coinc     <= n_coinc;
            r_status    <= n_status;
            r_j         <= n_j;
            r_div_cnt   <= n_div_cnt;
            r_row       <= n_row;
            if (i_cfg_we && i_cfg_idx == chb_pkg::CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data[chb_pkg::CNT_W-1:0];
            end
        end
    end

endmodule

FILE: sv/chb_dp.sv
// Datapath: node store, difference, products, restoring dividers, accumulators.
`timescale 1ns / 1ps
module chb_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  chb_pkg::t_dp_cmd                       i_cmd,
    output chb_pkg::t_dp_stat                      o_stat,
    input  logic signed [chb_pkg::COORD_W-1:0]     i_coord_x,
    input  logic signed [chb_pkg::COORD_W-1:0]     i_coord_y,
    input  logic signed [chb_pkg::COORD_W-1:0]     i_coord_z,
    input  logic                                   i_cfg_we,
    input  logic [chb_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [chb_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic signed [chb_pkg::ENTRY_W-1:0]     o_term [chb_pkg::NUM_TERMS],
    output logic [chb_pkg::STATUS_W-1:0]           o_status
);

    localparam int SAT_W = (chb_pkg::ACC_W > chb_pkg::ENTRY_W) ? chb_pkg::ACC_W :
                           chb_pkg::ENTRY_W;
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        SAT_W'(signed'({1'b0, {(chb_pkg::ENTRY_W-1){1'b1}}}));
    localparam logic signed [SAT_W-1:0] SAT_MIN =
        SAT_W'(signed'({1'b1, {(chb_pkg::ENTRY_W-1){1'b0}}}));

    logic [chb_pkg::WORD_W-1:0]            r_mem [chb_pkg::MAX_NODES];
    logic [chb_pkg::WORD_W-1:0]            r_rd_data;
    logic [chb_pkg::RAD_W-1:0]             r_radius;
    logic signed [chb_pkg::COORD_W-1:0]    r_base [3];
    logic signed [chb_pkg::DIFF_W-1:0]     r_d    [3];
    logic signed [chb_pkg::PROD_W-1:0]     r_prod [chb_pkg::NUM_TERMS];
    logic [chb_pkg::SUMSQ_W-1:0]           r_s;
    logic [chb_pkg::REM_W-1:0]             r_rem  [chb_pkg::NUM_TERMS];
    logic [chb_pkg::QUO_W-1:0]             r_quo  [chb_pkg::NUM_TERMS];
    logic                                  r_neg  [chb_pkg::NUM_TERMS];
    logic signed [chb_pkg::ACC_W-1:0]      r_acc  [chb_pkg::NUM_TERMS];
    logic signed [chb_pkg::ENTRY_W-1:0]    r_out  [chb_pkg::NUM_TERMS];
    logic [chb_pkg::STATUS_W-1:0]          r_out_status;
    logic signed [chb_pkg::COORD_W-1:0]    w_rd_coord [3];
    logic signed [chb_pkg::ENTRY_W-1:0]    w_clamp [chb_pkg::NUM_TERMS];
    logic [chb_pkg::NUM_TERMS-1:0]         w_sat;

    // Node store, one write or one read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.mem_addr] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[i_cmd.mem_addr];
        end
    end

    // Cutoff register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= chb_pkg::RADIUS_SQ_RST;
        end else if (i_cfg_we && i_cfg_idx == chb_pkg::CFG_RADIUS_SQ) begin
            r_radius <= i_cfg_data[chb_pkg::RAD_W-1:0];
        end
    end

    // Unpack the read word into its three axes
    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_rd_coord[a] = r_rd_data[a*chb_pkg::COORD_W +: chb_pkg::COORD_W];

        always_ff @(posedge i_clk) begin
            if (i_cmd.latch_base) begin
                r_base[a] <= w_rd_coord[a];
            end
            if (i_cmd.latch_diff) begin
                r_d[a] <= chb_pkg::DIFF_W'(w_rd_coord[a]) - chb_pkg::DIFF_W'(r_base[a]);
            end
        end
    end

    // Squared distance
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_s <= chb_pkg::SUMSQ_W'(r_prod[chb_pkg::T_XX]) +
                   chb_pkg::SUMSQ_W'(r_prod[chb_pkg::T_YY]) +
                   chb_pkg::SUMSQ_W'(r_prod[chb_pkg::T_ZZ]);
        end
    end

    assign o_stat.s_zero = (r_s == '0);
    assign o_stat.s_far  = chb_pkg::RAD_W'(r_s) > r_radius;

    // One lane per unique term: product, divider, accumulator, clamp
    for (genvar t = 0; t < chb_pkg::NUM_TERMS; t++) begin : g_term
        logic                              w_ge;
        logic [chb_pkg::REM_W-1:0]         w_diff;
        logic signed [chb_pkg::ACC_W-1:0]  w_q;
        logic signed [SAT_W-1:0]           w_ext;

        assign w_ge   = r_rem[t] >= chb_pkg::REM_W'(r_s);
        assign w_diff = w_ge ? (r_rem[t] - chb_pkg::REM_W'(r_s)) : r_rem[t];
        assign w_q    = chb_pkg::ACC_W'(signed'({1'b0, r_quo[t]}));
        assign w_ext  = SAT_W'(r_acc[t]);

        // Clamp to the signed entry range
        always_comb begin
            w_sat[t]   = 1'b0;
            w_clamp[t] = chb_pkg::ENTRY_W'(w_ext);
            if (w_ext > SAT_MAX) begin
                w_sat[t]   = 1'b1;
                w_clamp[t] = chb_pkg::ENTRY_W'(SAT_MAX);
            end else if (w_ext < SAT_MIN) begin
                w_sat[t]   = 1'b1;
                w_clamp[t] = chb_pkg::ENTRY_W'(SAT_MIN);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_prod[t] <= chb_pkg::PROD_W'(r_d[chb_pkg::TERM_A[t]] *
                                              r_d[chb_pkg::TERM_B[t]]);
            end
            // Load magnitude and sign, one quotient bit per step after
            if (i_cmd.sum) begin
                r_neg[t] <= r_prod[t][chb_pkg::PROD_W-1];
                r_rem[t] <= chb_pkg::REM_W'(r_prod[t][chb_pkg::PROD_W-1] ?
                                            -r_prod[t] : r_prod[t]);
                r_quo[t] <= '0;
            end else if (i_cmd.div_step) begin
                r_rem[t] <= {w_diff[chb_pkg::REM_W-2:0], 1'b0};
                r_quo[t] <= {r_quo[t][chb_pkg::QUO_W-2:0], w_ge};
            end
            if (i_cmd.acc_clear) begin
                r_acc[t] <= '0;
            end else if (i_cmd.acc_add) begin
                r_acc[t] <= (r_neg[t] ^ i_cmd.acc_sub) ? (r_acc[t] - w_q) : (r_acc[t] + w_q);
            end
            if (i_cmd.out_load) begin
                r_out[t] <= w_clamp[t];
            end
        end

        assign o_term[t] = r_out[t];
    end

    // Result status; any clamp overrides
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= (|w_sat) ? chb_pkg::ST_SATURATED : i_cmd.status;
        end
    end

    assign o_status = r_out_status;

endmodule

FILE: sv/cutoff_network_hessian_blocks.sv
// Top level of the elastic network Hessian block unit.
// Usage:
//   in_ch carries one request: a load (operation 0) writes coord_x/y/z of node
//   row_node into the node store; a query (operation 1) asks for the 3x3 block
//   at (row_node, col_node). out_ch returns one result for every request.
//   The config port writes node_count (index 0) or radius_squared (index 1);
//   write it only while no request is in progress.
// Sequencing:
//   A load or a bad index goes straight to the result. An off-diagonal query
//   handles the one pair (row_node, col_node); a diagonal query walks every
//   other node below node_count. Each pair within the cutoff costs one store
//   read, one product stage, one sum and 17 steps of the six restoring
//   dividers. One request is in progress at a time.
// Reset: node_count returns to 1 and radius_squared to 15.0^2; the node
//   store is not cleared, nodes must be loaded before they are queried.
// Backpressure: a finished result sits in the output register; a new request
//   is taken meanwhile and waits at its end until the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cutoff_network_hessian_blocks (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    chb_in_if.sink                          in_ch,
    chb_out_if.source                       out_ch,
    input  logic                            i_cfg_we,
    input  logic [chb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [chb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    chb_pkg::t_dp_cmd                     w_cmd;
    chb_pkg::t_dp_stat                    w_stat;
    logic signed [chb_pkg::ENTRY_W-1:0]   w_term [chb_pkg::NUM_TERMS];
    logic [chb_pkg::STATUS_W-1:0]         w_status;

    // Control
    chb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_operation (in_ch.operation),
        .i_row_node  (in_ch.row_node),
        .i_col_node  (in_ch.col_node),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage
    chb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_coord_x  (in_ch.coord_x),
        .i_coord_y  (in_ch.coord_y),
        .i_coord_z  (in_ch.coord_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_term     (w_term),
        .o_status   (w_status)
    );

    // Symmetric block from six unique terms
    assign out_ch.entry_xx = w_term[chb_pkg::T_XX];
    assign out_ch.entry_xy = w_term[chb_pkg::T_XY];
    assign out_ch.entry_xz = w_term[chb_pkg::T_XZ];
    assign out_ch.entry_yx = w_term[chb_pkg::T_XY];
    assign out_ch.entry_yy = w_term[chb_pkg::T_YY];
    assign out_ch.entry_yz = w_term[chb_pkg::T_YZ];
    assign out_ch.entry_zx = w_term[chb_pkg::T_XZ];
    assign out_ch.entry_zy = w_term[chb_pkg::T_YZ];
    assign out_ch.entry_zz = w_term[chb_pkg::T_ZZ];
    assign out_ch.status   = w_status;

    // Checks
    `CHB_ASSERT_CLK(a_one_in_flight, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "request accepted while busy")
    `CHB_ASSERT_CLK(a_load_shows, w_cmd.out_load |=> out_ch.valid, "result loaded but not shown")
    `CHB_ASSERT_IMP(a_zero_block, out_ch.valid && (out_ch.status == chb_pkg::ST_LOADED || out_ch.status == chb_pkg::ST_BADINDEX), out_ch.entry_xx == '0 && out_ch.entry_yz == '0 && out_ch.entry_zz == '0, "load or bad index with nonzero block")

endmodule

FILE: tb/tb_cutoff_network_hessian_blocks.sv
// Self-checking testbench for the elastic network Hessian block unit.
`timescale 1ns / 1ps
module tb_cutoff_network_hessian_blocks;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint RADIUS_MAX  = 64'h0000_0FFF_FFFF_FFFF;

    typedef struct {
        logic                               op;
        logic [chb_pkg::NODE_W-1:0]         row;
        logic [chb_pkg::NODE_W-1:0]         col;
        logic signed [chb_pkg::COORD_W-1:0] x;
        logic signed [chb_pkg::COORD_W-1:0] y;
        logic signed [chb_pkg::COORD_W-1:0] z;
    } t_hreq;

    typedef struct packed {
        logic [8:0][chb_pkg::ENTRY_W-1:0] e;
        logic [chb_pkg::STATUS_W-1:0]     st;
    } t_blk_res;

    typedef enum {STEP_REQ, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind                    kind;
        t_hreq                         req;
        logic [chb_pkg::CFG_IDX_W-1:0] idx;
        longint                        val;
        bit                            fixed;
        logic [chb_pkg::STATUS_W-1:0]  st;
    } t_dir_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [chb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [chb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    chb_in_if  req_ch ();
    chb_out_if rsp_ch ();

    cutoff_network_hessian_blocks DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (req_ch),
        .out_ch     (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the node store and the registers
    logic [chb_pkg::WORD_W-1:0] node_copy [chb_pkg::MAX_NODES];
    bit                         node_seen [chb_pkg::MAX_NODES];
    longint                     cnt_reg;
    longint                     rad_reg;

    t_blk_res  blocks_due [$];
    t_dir_step dir_steps [$];
    int        err_count = 0;
    int        next_gap  = 0;
    bit        burst     = 0;
    longint    cycles    = 0;

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic longint axis_of(int idx, int ax);
        logic signed [chb_pkg::COORD_W-1:0] v;
        v = node_copy[idx][ax*chb_pkg::COORD_W +: chb_pkg::COORD_W];
        return longint'(v);
    endfunction

    // d d^T / s scaled by 2^16 for d = pos(b) - pos(a), zero beyond the cutoff; same is set for coincident nodes
    function automatic void pair_terms(int a, int b, output longint blk[9], output bit same);
        longint d[3];
        longint s, p, mag, q;
        s = 0;
        same = 0;
        for (int k = 0; k < 9; k++) blk[k] = 0;
        for (int r = 0; r < 3; r++) begin
            d[r] = axis_of(b, r) - axis_of(a, r);
            s += d[r] * d[r];
        end
        if (s == 0) begin
            same = 1;
            return;
        end
        if (s > rad_reg) return;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p = d[r] * d[c];
                mag = (p < 0) ? -p : p;
                q = (mag << 16) / s;
                blk[r*3+c] = (p < 0) ? -q : q;
            end
        end
    endfunction

    // Expected block for one request; loads update the shadow store
    function automatic t_blk_res hessian_block(t_hreq r);
        t_blk_res res;
        longint acc[9];
        longint blk[9];
        longint n;
        bit same, hit_same, clamped;
        int row, col;
        row = int'(r.row);
        col = int'(r.col);
        n = (cnt_reg > chb_pkg::MAX_NODES) ? longint'(chb_pkg::MAX_NODES) : cnt_reg;
        for (int k = 0; k < 9; k++) acc[k] = 0;
        hit_same = 0;
        clamped = 0;
        if (r.op == chb_pkg::OP_LOAD) begin
            node_copy[row] = {r.z, r.y, r.x};
            node_seen[row] = 1;
            res.st = chb_pkg::ST_LOADED;
        end else if (row >= n || col >= n) begin
            res.st = chb_pkg::ST_BADINDEX;
        end else if (row != col) begin
            pair_terms(row, col, blk, same);
            for (int k = 0; k < 9; k++) acc[k] = -blk[k];
            res.st = same ? chb_pkg::ST_COINCIDENT : chb_pkg::ST_OK;
        end else begin
            for (int j = 0; j < n; j++) begin
                if (j == row) continue;
                pair_terms(row, j, blk, same);
                hit_same |= same;
                for (int k = 0; k < 9; k++) acc[k] += blk[k];
            end
            for (int k = 0; k < 9; k++) begin
                if (acc[k] > 64'sd2147483647) begin
                    acc[k] = 64'sd2147483647;
                    clamped = 1;
                end else if (acc[k] < -64'sd2147483648) begin
                    acc[k] = -64'sd2147483648;
                    clamped = 1;
                end
            end
            res.st = clamped ? chb_pkg::ST_SATURATED :
                     (hit_same ? chb_pkg::ST_COINCIDENT : chb_pkg::ST_OK);
        end
        for (int k = 0; k < 9; k++) res.e[k] = acc[k][chb_pkg::ENTRY_W-1:0];
        return res;
    endfunction

    function automatic int draw_wait();
        return burst ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Drive one request, wait for its handshake, queue its expectation
    task automatic send(t_hreq r, bit fixed = 0,
                        logic [chb_pkg::STATUS_W-1:0] st = chb_pkg::ST_OK);
        t_blk_res want;
        repeat (next_gap) @(posedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= r.op;
        req_ch.row_node  <= r.row;
        req_ch.col_node  <= r.col;
        req_ch.coord_x   <= r.x;
        req_ch.coord_y   <= r.y;
        req_ch.coord_z   <= r.z;
        do @(posedge i_clk); while (!req_ch.ready);
        want = hessian_block(r);
        if (fixed) begin
            want.e  = '0;
            want.st = st;
        end
        blocks_due.push_back(want);
        next_gap = draw_wait();
        if (next_gap != 0) req_ch.valid <= 1'b0;
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        if (next_gap == 0) req_ch.valid <= 1'b0;
        next_gap = 0;
        while (blocks_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [chb_pkg::CFG_IDX_W-1:0] idx, longint val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[chb_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == chb_pkg::CFG_NODE_COUNT) cnt_reg = val & 64'h7FF;
        else rad_reg = val & RADIUS_MAX;
    endtask

    function automatic t_hreq mk_req(logic op, int row, int col, int x = 0, int y = 0,
                                     int z = 0);
        t_hreq r;
        r.op  = op;
        r.row = chb_pkg::NODE_W'(row);
        r.col = chb_pkg::NODE_W'(col);
        r.x   = chb_pkg::COORD_W'(x);
        r.y   = chb_pkg::COORD_W'(y);
        r.z   = chb_pkg::COORD_W'(z);
        return r;
    endfunction

    function automatic void add_req(t_hreq r, bit fixed = 0,
                                    logic [chb_pkg::STATUS_W-1:0] st = chb_pkg::ST_OK);
        t_dir_step s;
        s.kind  = STEP_REQ;
        s.req   = r;
        s.fixed = fixed;
        s.st    = st;
        dir_steps.push_back(s);
    endfunction

    function automatic void add_cfg(logic [chb_pkg::CFG_IDX_W-1:0] idx, longint val);
        t_dir_step s;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.val  = val;
        dir_steps.push_back(s);
    endfunction

    // Coordinates near the origin, so many pairs fall inside a 15-unit cutoff
    function automatic int near_coord();
        return int'($urandom_range(0, 6000)) - 3000;
    endfunction

    function automatic t_hreq rand_load(int n);
        t_hreq r;
        int pick, src, row;
        pick = int'($urandom_range(0, 99));
        row = (n > 0 && pick < 60) ? int'($urandom_range(0, n - 1))
                                   : int'($urandom_range(0, chb_pkg::MAX_NODES - 1));
        r = mk_req(chb_pkg::OP_LOAD, row, 0);
        r.col = chb_pkg::NODE_W'($urandom);
        pick = int'($urandom_range(0, 99));
        if (pick < 70) begin
            r.x = chb_pkg::COORD_W'(near_coord());
            r.y = chb_pkg::COORD_W'(near_coord());
            r.z = chb_pkg::COORD_W'(near_coord());
        end else if (pick < 85 || n == 0) begin
            r.x = chb_pkg::COORD_W'($urandom);
            r.y = chb_pkg::COORD_W'($urandom);
            r.z = chb_pkg::COORD_W'($urandom);
        end else begin
            // duplicate an existing node to force coincident pairs
            src = int'($urandom_range(0, n - 1));
            {r.z, r.y, r.x} = node_copy[src];
        end
        return r;
    endfunction

    function automatic t_hreq rand_query(int n);
        t_hreq r;
        r = mk_req(chb_pkg::OP_QUERY, 0, 0, int'($urandom), int'($urandom), int'($urandom));
        if (n == 0 || $urandom_range(0, 9) == 0) begin
            r.row = chb_pkg::NODE_W'($urandom);
            r.col = chb_pkg::NODE_W'($urandom);
            if (int'(r.row) < n && int'(r.col) < n && r.row == r.col && n > 64)
                r.col = chb_pkg::NODE_W'(n - 1);
        end else begin
            r.row = chb_pkg::NODE_W'($urandom_range(0, n - 1));
            r.col = ($urandom_range(0, 3) == 0) ? r.row
                                                : chb_pkg::NODE_W'($urandom_range(0, n - 1));
        end
        return r;
    endfunction

    // Result side: random stalls, compare against the oldest expectation
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_blk_res want;
        logic [8:0][chb_pkg::ENTRY_W-1:0] got;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = {rsp_ch.entry_zz, rsp_ch.entry_zy, rsp_ch.entry_zx,
                       rsp_ch.entry_yz, rsp_ch.entry_yy, rsp_ch.entry_yx,
                       rsp_ch.entry_xz, rsp_ch.entry_xy, rsp_ch.entry_xx};
                if (blocks_due.size() == 0) begin
                    report("result with no request outstanding", 1, 0);
                end else begin
                    want = blocks_due.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want.e[k])
                            report($sformatf("entry %0d", k), $signed(got[k]),
                                   $signed(want.e[k]));
                    if (rsp_ch.status !== want.st)
                        report("status", longint'(rsp_ch.status), longint'(want.st));
                end
                hold_left = draw_wait();
            end else if (hold_left > 0) begin
                hold_left--;
            end
            rsp_ch.ready <= (hold_left == 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int n;
        t_hreq r;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = chb_pkg::OP_LOAD;
        req_ch.row_node  = '0;
        req_ch.col_node  = '0;
        req_ch.coord_x   = '0;
        req_ch.coord_y   = '0;
        req_ch.coord_z   = '0;
        cnt_reg = longint'(chb_pkg::NODE_COUNT_RST);
        rad_reg = longint'(chb_pkg::RADIUS_SQ_RST);
        foreach (node_seen[i]) begin
            node_seen[i] = 0;
            node_copy[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, extremes, coincident, cutoff, bad index
        add_req(mk_req(chb_pkg::OP_LOAD, 0, 0), 1, chb_pkg::ST_LOADED);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 0));
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 1), 1, chb_pkg::ST_BADINDEX);
        add_req(mk_req(chb_pkg::OP_QUERY, 1023, 0), 1, chb_pkg::ST_BADINDEX);
        add_req(mk_req(chb_pkg::OP_LOAD, 1, 1023, 524287, 524287, 524287), 1,
                chb_pkg::ST_LOADED);
        add_req(mk_req(chb_pkg::OP_LOAD, 2, 0, -524288, -524288, -524288), 1,
                chb_pkg::ST_LOADED);
        add_req(mk_req(chb_pkg::OP_LOAD, 3, 0, 0, 0, 0), 1, chb_pkg::ST_LOADED);
        add_req(mk_req(chb_pkg::OP_LOAD, 1023, 0, 256, -256, 512), 1, chb_pkg::ST_LOADED);
        add_cfg(chb_pkg::CFG_NODE_COUNT, 4);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 3), 1, chb_pkg::ST_COINCIDENT);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 1), 1, chb_pkg::ST_OK);
        add_req(mk_req(chb_pkg::OP_QUERY, 1, 2));
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 0));
        add_cfg(chb_pkg::CFG_RADIUS_SQ, RADIUS_MAX);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 1));
        add_req(mk_req(chb_pkg::OP_QUERY, 1, 2));
        add_req(mk_req(chb_pkg::OP_QUERY, 2, 2));
        add_req(mk_req(chb_pkg::OP_LOAD, 2, 0, 256, 0, 0), 1, chb_pkg::ST_LOADED);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 2));
        add_req(mk_req(chb_pkg::OP_QUERY, 1, 1));
        add_cfg(chb_pkg::CFG_RADIUS_SQ, 0);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 2), 1, chb_pkg::ST_OK);
        add_req(mk_req(chb_pkg::OP_QUERY, 3, 3));
        add_cfg(chb_pkg::CFG_NODE_COUNT, 0);
        add_req(mk_req(chb_pkg::OP_QUERY, 0, 0), 1, chb_pkg::ST_BADINDEX);
        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_CFG) set_reg(dir_steps[i].idx, dir_steps[i].val);
            else send(dir_steps[i].req, dir_steps[i].fixed, dir_steps[i].st);
        end

        // Random phases with small node counts
        for (int p = 0; p < 14; p++) begin
            burst = (p % 4 == 3);
            n = (p == 0) ? 0 : (p == 1) ? 1 : int'($urandom_range(2, 16));
            case ($urandom_range(0, 4))
                0: set_reg(chb_pkg::CFG_RADIUS_SQ, 0);
                1: set_reg(chb_pkg::CFG_RADIUS_SQ, RADIUS_MAX);
                2: set_reg(chb_pkg::CFG_RADIUS_SQ, longint'(chb_pkg::RADIUS_SQ_RST));
                3: set_reg(chb_pkg::CFG_RADIUS_SQ, longint'($urandom_range(1, 900)) << 16);
                default: set_reg(chb_pkg::CFG_RADIUS_SQ, {$urandom, $urandom} & RADIUS_MAX);
            endcase
            // every node under the count must hold coordinates before queries
            for (int i = 0; i < n; i++)
                if (!node_seen[i]) send(mk_req(chb_pkg::OP_LOAD, i, 0, near_coord(),
                                               near_coord(), near_coord()));
            set_reg(chb_pkg::CFG_NODE_COUNT, n);
            for (int k = 0; k < 40; k++) begin
                r = ($urandom_range(0, 99) < 25) ? rand_load(n) : rand_query(n);
                send(r);
            end
        end

        // Count above the store depth acts as the depth; pairs of loaded nodes only
        burst = 0;
        set_reg(chb_pkg::CFG_RADIUS_SQ, RADIUS_MAX);
        send(mk_req(chb_pkg::OP_LOAD, 5, 0, near_coord(), near_coord(), near_coord()));
        send(mk_req(chb_pkg::OP_LOAD, 1000, 0, near_coord(), near_coord(), near_coord()));
        set_reg(chb_pkg::CFG_NODE_COUNT, 2047);
        send(mk_req(chb_pkg::OP_QUERY, 1023, 0));
        send(mk_req(chb_pkg::OP_QUERY, 5, 1000));
        send(mk_req(chb_pkg::OP_QUERY, 1000, 1023));
        set_reg(chb_pkg::CFG_NODE_COUNT, chb_pkg::MAX_NODES);
        send(mk_req(chb_pkg::OP_QUERY, 1023, 5));

        drain();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
